[design/ngf_pkg.sv]
`timescale 1ns / 1ps

package ngf_pkg;

  localparam int PIX_W = 16;
  localparam int GRAD_W = PIX_W + 1;
  localparam int MAG_W = PIX_W;
  localparam int SQ_W = 2 * MAG_W;
  localparam int S_W = SQ_W + 2;
  localparam int K_W = 15;
  localparam int A_W = S_W + 2 * MAG_W + 2;
  localparam int B_W = S_W + MAG_W + 2;
  localparam int N_W = 2 * SQ_W;
  localparam int OUT_W = 16;

  localparam int IDX_W = 2;
  localparam logic [IDX_W-1:0] REG_WIDTH = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_ETA = 2'd2;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic                     fe;
  } diff_t;

  // a: u^2*S, b: u*S with u = 2k-1, n: g^2 * 2^32
  typedef struct packed {
    logic [A_W-1:0]        a;
    logic signed [B_W-1:0] b;
    logic [N_W-1:0]        n;
    logic [K_W-1:0]        k;
    logic                  neg;
    logic                  zero;
  } lane_t;

  typedef struct packed {
    logic [S_W-1:0] s;
    lane_t          x;
    lane_t          y;
    logic           fe;
  } srch_t;

  typedef struct packed {
    logic [OUT_W-1:0] dir_x;
    logic [OUT_W-1:0] dir_y;
    logic             fe;
  } res_t;

  // Try setting bit j of k: accept when (2k'-1)^2 * S <= g^2 * 2^32.
  function automatic lane_t search_step(lane_t l, logic [S_W-1:0] s, int unsigned j);
    logic signed [A_W+1:0] cand;
    logic signed [A_W+1:0] bx;
    logic [A_W+1:0]        sx;
    lane_t                 r;
    r = l;
    bx = {{(A_W + 2 - B_W){l.b[B_W-1]}}, l.b};
    sx = {{(A_W + 2 - S_W){1'b0}}, s};
    cand = $signed({2'b00, l.a}) + (bx <<< (j + 2)) + $signed(sx << (2 * j + 2));
    if (!cand[A_W+1] && $unsigned(cand) <= {{(A_W + 2 - N_W){1'b0}}, l.n}) begin
      r.a = cand[A_W-1:0];
      r.b = l.b + $signed({{(B_W - S_W){1'b0}}, s} << (j + 1));
      r.k = l.k | (K_W'(1) << j);
    end
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] finish_q15(lane_t l);
    if (l.zero) begin
      return '0;
    end else if (l.neg) begin
      return OUT_W'(17'h10000 - {2'b00, l.k});
    end
    return {1'b0, l.k};
  endfunction

endpackage

[design/normalized_gradient_field.sv]
`timescale 1ns / 1ps
// Path: a result shows on m_tvalid after the transfer of the pixel below it, through
//   line buffer read, difference, squares, sum, 15 search stages, rounding, output queue.
// Throughput: one item per cycle unless the queue is full; each search stage registers one shift-add compare.
// Reset: clears column and row counters, valid bits and the output queue, and loads
//   width 1024, height 1, eta 1. The line buffer is not cleared and needs no sweep.

module normalized_gradient_field #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [15:0]                 s_tdata,   // [15:0] pixel_value
  input  logic                        s_tuser,   // [0] flush
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [31:0]                 m_tdata,   // [15:0] dir_x, [31:16] dir_y
  output logic                        m_tlast,
  input  logic                        cfg_write,
  input  logic [ngf_pkg::IDX_W-1:0]   cfg_index,
  input  logic [15:0]                 cfg_data
);

  logic [10:0] image_width;
  logic [15:0] image_height;
  logic [15:0] smoothing_eta;

  logic           en, acc, dvld, nvld, push, pop;
  ngf_pkg::diff_t diff;
  ngf_pkg::res_t  nres;
  ngf_pkg::res_t  fifo_q [0:1];
  ngf_pkg::res_t  head;
  logic           wptr, rptr;
  logic [1:0]     cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 11'd1024;
      image_height <= 16'd1;
      smoothing_eta <= 16'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ngf_pkg::REG_WIDTH:  image_width <= cfg_data[10:0];
        ngf_pkg::REG_HEIGHT: image_height <= cfg_data;
        ngf_pkg::REG_ETA:    smoothing_eta <= cfg_data;
        default: ;
      endcase
    end
  end

  // advance the whole pipeline while the output queue has a free slot
  assign en = cnt != 2'd2;
  assign s_tready = en;
  assign acc = s_tvalid && s_tready;

  ngf_line #(.MAX_WIDTH(MAX_WIDTH)) u_line (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .acc          (acc),
    .pixel        (s_tdata),
    .flush        (s_tuser),
    .image_width  (image_width),
    .image_height (image_height),
    .out_vld      (dvld),
    .out_diff     (diff)
  );

  ngf_norm u_norm (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (dvld),
    .in_diff (diff),
    .eta     (smoothing_eta),
    .out_vld (nvld),
    .out_res (nres)
  );

  assign push = en && nvld;
  assign pop = m_tvalid && m_tready;
  assign head = fifo_q[rptr];
  assign m_tvalid = cnt != 2'd0;
  assign m_tdata = {head.dir_y, head.dir_x};
  assign m_tlast = head.fe;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_q[wptr] <= nres;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("output queue count out of range");
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (cnt == $past(cnt) - 2'd1))
    else $error("output queue count lost a transfer");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!en && nvld) |=> nvld)
    else $error("pipeline dropped a result during stall");
`endif

endmodule

[design/ngf_ram.sv]
`timescale 1ns / 1ps

module ngf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/ngf_line.sv]
`timescale 1ns / 1ps

module ngf_line #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             acc,
  input  logic [ngf_pkg::PIX_W-1:0]        pixel,
  input  logic                             flush,
  input  logic [10:0]                      image_width,
  input  logic [15:0]                      image_height,
  output logic                             out_vld,
  output ngf_pkg::diff_t                   out_diff
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WL = $clog2(MAX_WIDTH + 1);
  localparam int PW = ngf_pkg::PIX_W;

  logic [CW-1:0] col;
  logic [15:0]   row;
  logic [WL-1:0] w_lim;
  logic [15:0]   h_lim;
  logic          draining, last_col, act, emit, wr, byp;
  logic [CW-1:0] raddr;
  logic [PW-1:0] rdata;

  logic          v1, e1, fe1, last1, byp1;
  logic [PW-1:0] below1, prev_rd, rd, right;

  always_comb begin
    if (image_width == 11'd0) begin
      w_lim = WL'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_lim = WL'(MAX_WIDTH);
    end else begin
      w_lim = WL'(image_width);
    end
    h_lim = (image_height == 16'd0) ? 16'd1 : image_height;
    draining = row >= h_lim;
    last_col = (32'(col) + 32'd1) >= 32'(w_lim);
    act = acc && (flush ? draining : !draining);
    emit = act && (flush || row != 16'd0);
    wr = acc && !flush && !draining;
    // this read is the right neighbor now and the center of the next step
    raddr = last_col ? '0 : CW'(32'(col) + 32'd1);
    byp = wr && raddr == col;
  end

  ngf_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_row_store (
    .clk   (clk),
    .we    (wr),
    .waddr (col),
    .wdata (pixel),
    .re    (act),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      v1 <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      if (act) begin
        if (last_col) begin
          col <= '0;
          row <= flush ? 16'd0 : row + 16'd1;
        end else begin
          col <= col + CW'(1);
        end
      end
      v1 <= act;
      out_vld <= v1 && e1;
    end
  end

  always_comb begin
    rd = byp1 ? below1 : rdata;
    right = last1 ? '0 : rd;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1 <= emit;
      fe1 <= flush && last_col;
      last1 <= last_col;
      byp1 <= byp;
      below1 <= flush ? '0 : pixel;
      if (v1) begin
        prev_rd <= rd;
      end
      out_diff.gx <= $signed({right[PW-1], right}) - $signed({prev_rd[PW-1], prev_rd});
      out_diff.gy <= $signed({below1[PW-1], below1}) - $signed({prev_rd[PW-1], prev_rd});
      out_diff.fe <= fe1;
    end
  end

endmodule

[design/ngf_step.sv]
`timescale 1ns / 1ps

module ngf_step #(
  parameter int unsigned J = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_vld,
  input  ngf_pkg::srch_t in_item,
  output logic           out_vld,
  output ngf_pkg::srch_t out_item
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item.s <= in_item.s;
      out_item.fe <= in_item.fe;
      out_item.x <= ngf_pkg::search_step(in_item.x, in_item.s, J);
      out_item.y <= ngf_pkg::search_step(in_item.y, in_item.s, J);
    end
  end

endmodule

[design/ngf_norm.sv]
`timescale 1ns / 1ps

module ngf_norm (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_vld,
  input  ngf_pkg::diff_t in_diff,
  input  logic [15:0]    eta,
  output logic           out_vld,
  output ngf_pkg::res_t  out_res
);

  localparam int MW = ngf_pkg::MAG_W;
  localparam int SQ = ngf_pkg::SQ_W;
  localparam int SW = ngf_pkg::S_W;
  localparam int KW = ngf_pkg::K_W;

  logic signed [ngf_pkg::GRAD_W-1:0] nx, ny;
  logic [MW-1:0] ax, ay;

  logic          va, fea, negx, negy, zx, zy;
  logic [SQ-1:0] sqx, sqy, sqe;

  logic           vld_c [0:KW];
  ngf_pkg::srch_t item_c [0:KW];
  logic [SW-1:0]  s;

  always_comb begin
    nx = -in_diff.gx;
    ny = -in_diff.gy;
    ax = in_diff.gx[ngf_pkg::GRAD_W-1] ? nx[MW-1:0] : in_diff.gx[MW-1:0];
    ay = in_diff.gy[ngf_pkg::GRAD_W-1] ? ny[MW-1:0] : in_diff.gy[MW-1:0];
    s = SW'(sqx) + SW'(sqy) + SW'(sqe);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vld_c[0] <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      va <= in_vld;
      vld_c[0] <= va;
      out_vld <= vld_c[KW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx <= ax * ax;
      sqy <= ay * ay;
      sqe <= eta * eta;
      negx <= in_diff.gx[ngf_pkg::GRAD_W-1];
      negy <= in_diff.gy[ngf_pkg::GRAD_W-1];
      zx <= in_diff.gx == '0;
      zy <= in_diff.gy == '0;
      fea <= in_diff.fe;

      // start the search at k = 0, u = -1
      item_c[0].s <= s;
      item_c[0].fe <= fea;
      item_c[0].x.a <= ngf_pkg::A_W'(s);
      item_c[0].x.b <= -$signed(ngf_pkg::B_W'(s));
      item_c[0].x.n <= {sqx, {SQ{1'b0}}};
      item_c[0].x.k <= '0;
      item_c[0].x.neg <= negx;
      item_c[0].x.zero <= zx;
      item_c[0].y.a <= ngf_pkg::A_W'(s);
      item_c[0].y.b <= -$signed(ngf_pkg::B_W'(s));
      item_c[0].y.n <= {sqy, {SQ{1'b0}}};
      item_c[0].y.k <= '0;
      item_c[0].y.neg <= negy;
      item_c[0].y.zero <= zy;

      out_res.dir_x <= ngf_pkg::finish_q15(item_c[KW].x);
      out_res.dir_y <= ngf_pkg::finish_q15(item_c[KW].y);
      out_res.fe <= item_c[KW].fe;
    end
  end

  for (genvar i = 0; i < KW; i++) begin : g_step
    ngf_step #(.J(KW - 1 - i)) u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_vld   (vld_c[i]),
      .in_item  (item_c[i]),
      .out_vld  (vld_c[i+1]),
      .out_item (item_c[i+1])
    );
  end

endmodule
